// File: src/multipath_hop_chooser_defines.svh
// assertion macros for the multipath hop chooser
// used by the top level; expects clk and rst_n in the including scope
`ifndef MULTIPATH_HOP_CHOOSER_DEFINES_SVH
`define MULTIPATH_HOP_CHOOSER_DEFINES_SVH

// same-cycle implication, held off during reset
`define MHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define MHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: src/mhc_pkg.sv
// shared types, constants and the hash mix step for the multipath hop chooser
// no dependencies
package mhc_pkg;

  localparam int MAX_HOPS  = 64;
  localparam int HOP_W     = 7;
  localparam int CHOICE_W  = 6;
  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam int MIX_STEPS = 9;
  localparam int DIV_BITS  = KEY_W;
  localparam int CNT_W     = $clog2(DIV_BITS);
  localparam int MIX_IDX_W = 4;

  localparam logic [KEY_W-1:0]  GOLDEN        = 32'h9e3779b9;
  localparam logic [SIZE_W-1:0] RR_SIZE_LIMIT = 16'd128;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROUTE = 2'd1;
  localparam logic [1:0] ST_UNSET    = 2'd2;

  // strategy codes
  localparam logic [1:0] STRAT_UNSET = 2'd0;
  localparam logic [1:0] STRAT_HASH  = 2'd1;
  localparam logic [1:0] STRAT_RR    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SALT     = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]  flow_id;
    logic [KEY_W-1:0]  path_id;
    logic [SIZE_W-1:0] packet_size;
    logic [HOP_W-1:0]  hop_count;
  } in_item_t;

  typedef struct packed {
    logic [CHOICE_W-1:0] hop_choice;
    logic [1:0]          status;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic                 classify;
    logic                 mix;
    logic                 div;
    logic                 fin;
    logic [MIX_IDX_W-1:0] mix_idx;
  } mhc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_hash;
  } mhc_sts_t;

  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] c;
  } mix_t;

  // one line of the jenkins 96-bit mix
  function automatic mix_t mix_step(logic [MIX_IDX_W-1:0] idx, mix_t s);
    mix_t r;
    r = s;
    case (idx)
      4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
      4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
      4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
      4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
      4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
      4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
      4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
      4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
      4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

// File: src/multipath_hop_chooser.sv
// multipath hop chooser top level: controller plus datapath
// depends on mhc_pkg, mhc_ctrl, mhc_dp and multipath_hop_chooser_defines.svh
//
// Picks one of up to 64 equal-cost next hops per packet. The input channel
// (in_valid/in_ready/in_data) carries flow id, path id, packet size and hop
// count; the result channel (out_valid/out_ready/out_data) carries the hop
// index and a status code. The cfg_ port writes the strategy (index 0) and
// the hash salt (index 1); the user must write them only while the block
// is idle, as the block itself does not enforce this. One item is worked
// on at a time, and one finished result may wait in the output register.
// A hashed item passes through load, classify, the jenkins mix (one mix
// line a cycle), the serial remainder of the 32-bit hash (one dividend bit
// a cycle) and the result state. Items that need no hash (no route, one
// hop, unset or reserved strategy, large packets in round robin) go from
// classify straight to the result state. in_ready returns together with
// the result entering the output register, so a new item is taken while
// the previous result waits. If the receiver stalls, the result waits in
// the output register with its payload held; the next finished item then
// waits in the controller's last state and in_ready stays low. Reset is
// synchronous: strategy, salt and the round-robin position clear to zero
// and no result is pending.
`include "multipath_hop_chooser_defines.svh"

module multipath_hop_chooser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mhc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mhc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mhc_pkg::KEY_W-1:0]     cfg_data
);

  mhc_pkg::mhc_cmd_t cmd;
  mhc_pkg::mhc_sts_t sts;

  // sequencing
  mhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash, remainder and counter
  mhc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a transfer in makes the block busy
  `MHC_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)

  // only defined status codes leave the block
  `MHC_ASSERT_NOW(a_status_code, out_valid,
    out_data.status == mhc_pkg::ST_OK || out_data.status == mhc_pkg::ST_NO_ROUTE ||
    out_data.status == mhc_pkg::ST_UNSET)

  // an error result always carries hop zero
  `MHC_ASSERT_NOW(a_error_hop_zero, out_valid && out_data.status != mhc_pkg::ST_OK,
    out_data.hop_choice == '0)

endmodule

// File: src/mhc_ctrl.sv
// controller state machine for the multipath hop chooser
// depends on mhc_pkg; drives the datapath through mhc_cmd_t
module mhc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mhc_pkg::mhc_sts_t sts,
  output mhc_pkg::mhc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_MIX,
    S_DIV,
    S_FIN
  } state_t;

  localparam logic [mhc_pkg::CNT_W-1:0] MIX_LAST = mhc_pkg::CNT_W'(mhc_pkg::MIX_STEPS - 1);
  localparam logic [mhc_pkg::CNT_W-1:0] DIV_LAST = mhc_pkg::CNT_W'(mhc_pkg::DIV_BITS - 1);

  state_t                      state_r, state_nxt;
  logic [mhc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mix_idx   = cnt_r[mhc_pkg::MIX_IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.need_hash ? S_MIX : S_FIN;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (cnt_r == MIX_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/mhc_dp.sv
// datapath of the multipath hop chooser: config registers, hash mix,
// serial remainder and round-robin counter; depends on mhc_pkg
module mhc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mhc_pkg::KEY_W-1:0]         cfg_data,
  input  mhc_pkg::in_item_t                 in_data,
  output mhc_pkg::out_item_t                out_data,
  input  mhc_pkg::mhc_cmd_t                 cmd,
  output mhc_pkg::mhc_sts_t                 sts
);

  logic [1:0]                    strategy_r;
  logic [mhc_pkg::KEY_W-1:0]     salt_r;
  logic [mhc_pkg::HOP_W-1:0]     rr_pos_r, rr_pos_nxt;

  mhc_pkg::in_item_t             item_r;
  logic [mhc_pkg::HOP_W-1:0]     n_r, n_sat;
  mhc_pkg::mix_t                 mix_r, mix_nxt;
  logic [mhc_pkg::CHOICE_W-1:0]  rem_r, rem_nxt;
  logic [mhc_pkg::HOP_W-1:0]     rem_shift;
  logic [mhc_pkg::CHOICE_W-1:0]  choice_r, choice_nxt;
  logic [1:0]                    status_r, status_nxt;
  logic                          hashed_r;
  logic [mhc_pkg::HOP_W-1:0]     pos_use;
  logic                          many_hops;
  mhc_pkg::out_item_t            out_r;

  assign out_data = out_r;

  // hop count saturates at the table size
  assign n_sat = (in_data.hop_count > mhc_pkg::HOP_W'(mhc_pkg::MAX_HOPS))
               ? mhc_pkg::HOP_W'(mhc_pkg::MAX_HOPS) : in_data.hop_count;

  // hashing is needed for hash mode and for short packets in round robin
  assign many_hops = (n_r > mhc_pkg::HOP_W'(1));
  assign sts.need_hash = many_hops &&
    ((strategy_r == mhc_pkg::STRAT_HASH) ||
     ((strategy_r == mhc_pkg::STRAT_RR) && (item_r.packet_size < mhc_pkg::RR_SIZE_LIMIT)));

  // round-robin position, cleared once it reaches the hop count
  assign pos_use = (rr_pos_r >= n_r) ? '0 : rr_pos_r;

  // classify outcome
  always_comb begin
    choice_nxt = '0;
    status_nxt = mhc_pkg::ST_OK;
    rr_pos_nxt = rr_pos_r;
    if (n_r == '0) begin
      status_nxt = mhc_pkg::ST_NO_ROUTE;
    end else if (!many_hops || sts.need_hash) begin
      status_nxt = mhc_pkg::ST_OK;
    end else if (strategy_r == mhc_pkg::STRAT_RR) begin
      choice_nxt = pos_use[mhc_pkg::CHOICE_W-1:0];
      rr_pos_nxt = pos_use + 1'b1;
    end else begin
      status_nxt = mhc_pkg::ST_UNSET;
    end
  end

  // one restoring remainder step per cycle, dividend msb first
  assign rem_shift = {rem_r, mix_r.c[mhc_pkg::KEY_W-1]};
  assign rem_nxt   = (rem_shift >= n_r) ? mhc_pkg::CHOICE_W'(rem_shift - n_r)
                                        : rem_shift[mhc_pkg::CHOICE_W-1:0];

  // hash state: load keys, mix line by line, then shift out during division
  always_comb begin
    mix_nxt = mix_r;
    if (cmd.classify) begin
      mix_nxt.a = mhc_pkg::GOLDEN + item_r.flow_id;
      mix_nxt.b = mhc_pkg::GOLDEN + salt_r;
      mix_nxt.c = item_r.path_id;
    end else if (cmd.mix) begin
      mix_nxt = mhc_pkg::mix_step(cmd.mix_idx, mix_r);
    end else if (cmd.div) begin
      mix_nxt.c = {mix_r.c[mhc_pkg::KEY_W-2:0], 1'b0};
    end
  end

  // configuration registers and round-robin counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= mhc_pkg::STRAT_UNSET;
      salt_r     <= '0;
      rr_pos_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mhc_pkg::REG_STRATEGY: strategy_r <= cfg_data[1:0];
          mhc_pkg::REG_SALT:     salt_r     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.classify) begin
        rr_pos_r <= rr_pos_nxt;
      end
    end
  end

  // item, hash and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      n_r    <= n_sat;
    end
    mix_r <= mix_nxt;
    if (cmd.classify) begin
      choice_r <= choice_nxt;
      status_r <= status_nxt;
      hashed_r <= sts.need_hash;
      rem_r    <= '0;
    end else if (cmd.div) begin
      rem_r <= rem_nxt;
    end
    if (cmd.fin) begin
      out_r.hop_choice <= hashed_r ? rem_r : choice_r;
      out_r.status     <= status_r;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the multipath hop chooser: hash, round robin and status paths
// depends on mhc_pkg and the multipath_hop_chooser top level
// stimulus tasks share one item sender and one result checker; a local predictor tracks state
module tb_top;
  import mhc_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          LONG_HOLD      = 400;
  localparam logic [1:0]  STRAT_RESERVED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;

  // predictor copy of the block's registers and state
  logic [1:0]       model_strategy;
  logic [KEY_W-1:0] model_salt;
  logic [HOP_W-1:0] rr_position;

  out_item_t expected_hops[$];
  int        fail_count;
  int        cycle_count;
  bit        tx_idle;
  bit        rx_idle;
  int        rx_hold_request;

  multipath_hop_chooser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // 96-bit mix of the three keys, the hash is the final c word
  function automatic logic [31:0] jenkins_hash(input logic [31:0] k_flow, input logic [31:0] k_path,
                                               input logic [31:0] k_salt);
    logic [31:0] a, b, c;
    a = GOLDEN + k_flow;
    b = GOLDEN + k_salt;
    c = k_path;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return c;
  endfunction

  // expected hop and status for one packet; advances the round-robin position
  function automatic out_item_t predict_hop(input in_item_t pkt);
    out_item_t   res;
    logic [31:0] n;
    logic [31:0] choice;
    n = (pkt.hop_count > MAX_HOPS) ? MAX_HOPS : {25'd0, pkt.hop_count};
    choice = 0;
    res.status = ST_OK;
    if (n == 0) begin
      res.status = ST_NO_ROUTE;
    end else if (n > 1) begin
      if (model_strategy == STRAT_HASH) begin
        choice = jenkins_hash(pkt.flow_id, pkt.path_id, model_salt) % n;
      end else if (model_strategy == STRAT_RR) begin
        if (pkt.packet_size < RR_SIZE_LIMIT) begin
          choice = jenkins_hash(pkt.flow_id, pkt.path_id, model_salt) % n;
        end else begin
          if ({25'd0, rr_position} >= n) rr_position = '0;
          choice = {25'd0, rr_position};
          rr_position = rr_position + 1'b1;
        end
      end else begin
        res.status = ST_UNSET;
      end
    end
    res.hop_choice = choice[CHOICE_W-1:0];
    return res;
  endfunction

  function automatic in_item_t make_pkt(input logic [31:0] flow, input logic [31:0] path,
                                        input logic [15:0] size, input logic [6:0] hops);
    in_item_t p;
    p.flow_id     = flow;
    p.path_id     = path;
    p.packet_size = size;
    p.hop_count   = hops;
    return p;
  endfunction

  // random packet, hop counts spread over empty, single, normal and oversized lists
  function automatic in_item_t random_pkt();
    int          r;
    logic [6:0]  hops;
    logic [15:0] size;
    r = $urandom_range(0, 19);
    if (r == 0) hops = 7'd0;
    else if (r == 1) hops = 7'd1;
    else if (r == 2) hops = 7'($urandom_range(65, 127));
    else hops = 7'($urandom_range(2, 64));
    size = $urandom_range(0, 1) ? 16'($urandom_range(0, 127)) : 16'($urandom_range(0, 65535));
    return make_pkt($urandom(), $urandom(), size, hops);
  endfunction

  // one register write, then the port goes quiet again
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_STRATEGY) model_strategy = value[1:0];
    else model_salt = value;
  endtask

  // offer one packet and record its expected result on transfer
  task automatic send_pkt(input in_item_t pkt);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    do @(posedge clk); while (in_ready !== 1'b1);
    expected_hops.push_back(predict_hop(pkt));
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reset values: strategy unset, so several hops report an error
  task automatic test_reset_defaults();
    send_pkt(make_pkt(32'h0, 32'h0, 16'd0, 7'd0));
    send_pkt(make_pkt(32'h1234_5678, 32'h9abc_def0, 16'd1500, 7'd1));
    send_pkt(make_pkt(32'hffff_ffff, 32'hffff_ffff, 16'd64, 7'd2));
    send_pkt(make_pkt(32'h5555_aaaa, 32'haaaa_5555, 16'hffff, 7'd64));
    send_pkt(make_pkt(32'h0, 32'hffff_ffff, 16'd128, 7'd127));
    drain();
  endtask

  // hash mode at key and hop count extremes, then the reserved strategy code
  task automatic test_hash_extremes();
    write_reg(REG_STRATEGY, {30'd0, STRAT_HASH});
    write_reg(REG_SALT, 32'h0);
    send_pkt(make_pkt(32'h0, 32'h0, 16'd0, 7'd2));
    send_pkt(make_pkt(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 7'd64));
    send_pkt(make_pkt(32'hffff_ffff, 32'h0, 16'd127, 7'd63));
    send_pkt(make_pkt(32'h0, 32'hffff_ffff, 16'd128, 7'd65));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd40, 7'd127));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd40, 7'd1));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd40, 7'd0));
    drain();
    write_reg(REG_SALT, 32'hffff_ffff);
    send_pkt(make_pkt(32'h8000_0001, 32'h7fff_fffe, 16'h8000, 7'd64));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd200, 7'd3));
    drain();
    write_reg(REG_STRATEGY, {30'd0, STRAT_RESERVED});
    send_pkt(make_pkt($urandom(), $urandom(), 16'd1000, 7'd4));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd1000, 7'd1));
    drain();
  endtask

  // round robin: size threshold, counter use and clear when the hop list shrinks
  task automatic test_round_robin();
    write_reg(REG_STRATEGY, {30'd0, STRAT_RR});
    write_reg(REG_SALT, $urandom());
    send_pkt(make_pkt($urandom(), $urandom(), 16'd127, 7'd5));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd128, 7'd5));
    send_pkt(make_pkt($urandom(), $urandom(), 16'hffff, 7'd5));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd0, 7'd5));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd9000, 7'd5));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd9000, 7'd2));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd9000, 7'd1));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd9000, 7'd0));
    send_pkt(make_pkt($urandom(), $urandom(), 16'd9000, 7'd127));
    drain();
  endtask

  // random phases, each under its own register setting and idling mix
  task automatic test_random_phases();
    int         r;
    logic [1:0] strat;
    logic [31:0] salt;
    for (int phase = 0; phase < 6; phase++) begin
      r = $urandom_range(0, 9);
      if (phase == 0) strat = STRAT_HASH;
      else if (phase == 1) strat = STRAT_RR;
      else if (r < 4) strat = STRAT_HASH;
      else if (r < 8) strat = STRAT_RR;
      else if (r == 8) strat = STRAT_UNSET;
      else strat = STRAT_RESERVED;
      salt = (phase == 1) ? 32'hffff_ffff : (phase == 2) ? 32'h0 : $urandom();
      write_reg(REG_STRATEGY, {30'($urandom()), strat});
      write_reg(REG_SALT, salt);
      tx_idle = (phase != 3);
      rx_idle = (phase != 3) && (phase != 5);
      repeat (60) send_pkt(random_pkt());
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off while packets keep coming, so the block backs up
  task automatic test_backpressure();
    write_reg(REG_STRATEGY, {30'd0, STRAT_RR});
    tx_idle = 1'b0;
    rx_hold_request = LONG_HOLD;
    repeat (12) send_pkt(random_pkt());
    tx_idle = 1'b1;
    drain();
  endtask

  // receiver side: random stalls plus the long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request > 0) begin
        stall_left = rx_hold_request;
        rx_hold_request = 0;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() + 1;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= rst_n;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_hops.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hop %0d status %0d",
                 $time, out_data.hop_choice, out_data.status);
        fail_count++;
      end else begin
        want = expected_hops.pop_front();
        if (out_data.hop_choice !== want.hop_choice) begin
          $display("%0t: hop_choice mismatch: expected %0d, actual %0d",
                   $time, want.hop_choice, out_data.hop_choice);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // test sequence
  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    rx_hold_request = 0;
    model_strategy  = STRAT_UNSET;
    model_salt      = '0;
    rr_position     = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_hash_extremes();
    test_round_robin();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_hops.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
